[sv/rsc_pkg.sv]
package rsc_pkg;

  // Character codes the checker reacts to
  localparam logic [7:0] CH_STAR      = 8'h2A;  // '*'
  localparam logic [7:0] CH_PLUS      = 8'h2B;  // '+'
  localparam logic [7:0] CH_QUEST     = 8'h3F;  // '?'
  localparam logic [7:0] CH_BAR       = 8'h7C;  // '|'
  localparam logic [7:0] CH_TILDE     = 8'h7E;  // '~'
  localparam logic [7:0] CH_LPAREN    = 8'h28;  // '('
  localparam logic [7:0] CH_RPAREN    = 8'h29;  // ')'
  localparam logic [7:0] CH_LBRACKET  = 8'h5B;  // '['
  localparam logic [7:0] CH_RBRACKET  = 8'h5D;  // ']'
  localparam logic [7:0] CH_BACKSLASH = 8'h5C;  // '\'

  // Printable / whitespace ranges
  localparam logic [7:0] CH_TAB       = 8'h09;
  localparam logic [7:0] CH_CR        = 8'h0D;
  localparam logic [7:0] CH_SPACE     = 8'h20;
  localparam logic [7:0] CH_GRAPH_LO  = 8'h21;
  localparam logic [7:0] CH_GRAPH_HI  = 8'h7E;

  // Sticky error flag positions
  localparam int FLAG_W     = 7;
  localparam int FLAG_CTRL  = 0;
  localparam int FLAG_ALT   = 1;
  localparam int FLAG_NEG   = 2;
  localparam int FLAG_QUANT = 3;
  localparam int FLAG_BRACK = 4;
  localparam int FLAG_PAREN = 5;
  localparam int FLAG_OVER  = 6;

  // Scan state carried from byte to byte (paren depth travels separately)
  typedef struct packed {
    logic              skip_next;
    logic              in_bracket;
    logic [FLAG_W-1:0] flags;
  } chk_state_t;

  // One verdict
  typedef struct packed {
    logic well_formed;
    logic bad_control_byte;
    logic misplaced_alternation;
    logic misplaced_negation;
    logic misplaced_quantifier;
    logic stray_close_bracket;
    logic stray_close_paren;
    logic open_bracket_at_end;
    logic open_paren_at_end;
    logic depth_overflow;
  } verdict_t;

endpackage

[sv/rsc_examine.sv]
// Checks one byte against its raw neighbors and advances the scan state.
module rsc_examine #(
  parameter int MAX_PAREN_DEPTH = 255
) (
  input  logic                                  en,
  input  logic [7:0]                            cur_byte,
  input  logic [7:0]                            prev_byte,
  input  logic                                  is_first,
  input  logic [7:0]                            next_byte,
  input  logic                                  at_end,
  input  rsc_pkg::chk_state_t                   st_i,
  input  logic [$clog2(MAX_PAREN_DEPTH+1)-1:0]  depth_i,
  output rsc_pkg::chk_state_t                   st_o,
  output logic [$clog2(MAX_PAREN_DEPTH+1)-1:0]  depth_o
);

  localparam int DEPTH_W = $clog2(MAX_PAREN_DEPTH + 1);
  localparam logic [DEPTH_W-1:0] DEPTH_MAX = DEPTH_W'(MAX_PAREN_DEPTH);

  logic is_ctrl;
  logic cur_quant;
  logic prev_quant;
  logic next_rparen;

  // Byte classes
  assign is_ctrl = !(((cur_byte >= rsc_pkg::CH_TAB) && (cur_byte <= rsc_pkg::CH_CR)) ||
                     (cur_byte == rsc_pkg::CH_SPACE) ||
                     ((cur_byte >= rsc_pkg::CH_GRAPH_LO) && (cur_byte <= rsc_pkg::CH_GRAPH_HI)));
  assign cur_quant  = (cur_byte == rsc_pkg::CH_STAR) || (cur_byte == rsc_pkg::CH_PLUS) ||
                      (cur_byte == rsc_pkg::CH_QUEST);
  assign prev_quant = (prev_byte == rsc_pkg::CH_STAR) || (prev_byte == rsc_pkg::CH_PLUS) ||
                      (prev_byte == rsc_pkg::CH_QUEST);
  assign next_rparen = !at_end && (next_byte == rsc_pkg::CH_RPAREN);

  // Rule check and state update; an escaped byte only clears the skip
  always_comb begin
    st_o    = st_i;
    depth_o = depth_i;
    if (en) begin
      if (st_i.skip_next) begin
        st_o.skip_next = 1'b0;
      end else begin
        if (is_ctrl) st_o.flags[rsc_pkg::FLAG_CTRL] = 1'b1;
        if (cur_byte == rsc_pkg::CH_BACKSLASH) begin
          st_o.skip_next = 1'b1;
        end else if (cur_byte == rsc_pkg::CH_BAR) begin
          if (is_first || at_end || (prev_byte == rsc_pkg::CH_LPAREN) || next_rparen)
            st_o.flags[rsc_pkg::FLAG_ALT] = 1'b1;
        end else if (cur_byte == rsc_pkg::CH_TILDE) begin
          if (is_first || at_end || next_rparen)
            st_o.flags[rsc_pkg::FLAG_NEG] = 1'b1;
        end else if (cur_quant) begin
          if (!st_i.in_bracket &&
              (is_first || prev_quant || (prev_byte == rsc_pkg::CH_LPAREN)))
            st_o.flags[rsc_pkg::FLAG_QUANT] = 1'b1;
        end else if (cur_byte == rsc_pkg::CH_LBRACKET) begin
          st_o.in_bracket = 1'b1;
        end else if (cur_byte == rsc_pkg::CH_RBRACKET) begin
          if (!st_i.in_bracket) st_o.flags[rsc_pkg::FLAG_BRACK] = 1'b1;
          else                  st_o.in_bracket = 1'b0;
        end else if ((cur_byte == rsc_pkg::CH_LPAREN) && !st_i.in_bracket) begin
          // saturate at the built maximum
          if (depth_i >= DEPTH_MAX) st_o.flags[rsc_pkg::FLAG_OVER] = 1'b1;
          else                      depth_o = depth_i + DEPTH_W'(1);
        end else if ((cur_byte == rsc_pkg::CH_RPAREN) && !st_i.in_bracket) begin
          if (depth_i != '0) depth_o = depth_i - DEPTH_W'(1);
          else               st_o.flags[rsc_pkg::FLAG_PAREN] = 1'b1;
        end
      end
    end
  end

endmodule

[sv/regex_syntax_checker.sv]
// Regular-expression syntax checker. The expression text streams in one byte per item
// on in_symbol, with in_last_symbol high on its final byte; one verdict item (well_formed
// plus one flag per error class) comes out of the result register after its final byte is
// taken, and the block is then clean for the next expression. An item is taken every cycle
// while in_stall is low: each byte waits in the one-byte lookahead register and is checked
// when its successor arrives; on the final byte the held byte and the final byte are both
// checked in that same cycle. A two-deep output buffer (result register plus skid) lets
// input go on while a verdict waits; in_stall rises only when both are full or in reset.
// A byte after a backslash is skipped unchecked. Paren depth saturates at MAX_PAREN_DEPTH.
module regex_syntax_checker #(
  parameter int MAX_PAREN_DEPTH = 255
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_symbol,
  input  logic       in_last_symbol,
  output logic       out_valid,
  input  logic       out_stall,
  output logic       out_well_formed,
  output logic       out_bad_control_byte,
  output logic       out_misplaced_alternation,
  output logic       out_misplaced_negation,
  output logic       out_misplaced_quantifier,
  output logic       out_stray_close_bracket,
  output logic       out_stray_close_paren,
  output logic       out_open_bracket_at_end,
  output logic       out_open_paren_at_end,
  output logic       out_depth_overflow
);

  localparam int DEPTH_W = $clog2(MAX_PAREN_DEPTH + 1);

  // Scan state
  logic [7:0]          held_byte_r;
  logic                held_valid_r;
  logic                held_first_r;
  logic [7:0]          before_held_r;
  rsc_pkg::chk_state_t st_r;
  logic [DEPTH_W-1:0]  depth_r;

  // Output buffer
  rsc_pkg::verdict_t   out_r, skid_r;
  logic                out_valid_r, skid_valid_r;

  logic                accept;
  logic                out_fire;
  logic                produce;
  rsc_pkg::chk_state_t st_a, st_b;
  logic [DEPTH_W-1:0]  depth_a, depth_b;
  logic [7:0]          prev_b;
  logic                first_b;
  logic                open_br, open_pa;
  rsc_pkg::verdict_t   verdict;

  assign in_stall = skid_valid_r || !rst_n;
  assign accept   = in_valid && !in_stall;
  assign out_fire = out_valid_r && !out_stall;
  assign produce  = accept && in_last_symbol;

  // Held byte, now that its successor is known
  rsc_examine #(.MAX_PAREN_DEPTH(MAX_PAREN_DEPTH)) u_exam_held (
    .en        (held_valid_r),
    .cur_byte  (held_byte_r),
    .prev_byte (before_held_r),
    .is_first  (held_first_r),
    .next_byte (in_symbol),
    .at_end    (1'b0),
    .st_i      (st_r),
    .depth_i   (depth_r),
    .st_o      (st_a),
    .depth_o   (depth_a)
  );

  // Neighbors seen by the incoming byte
  assign prev_b  = held_valid_r ? held_byte_r : before_held_r;
  assign first_b = held_valid_r ? 1'b0 : held_first_r;

  // Incoming byte as the final one of the expression
  rsc_examine #(.MAX_PAREN_DEPTH(MAX_PAREN_DEPTH)) u_exam_last (
    .en        (1'b1),
    .cur_byte  (in_symbol),
    .prev_byte (prev_b),
    .is_first  (first_b),
    .next_byte (8'h00),
    .at_end    (1'b1),
    .st_i      (st_a),
    .depth_i   (depth_a),
    .st_o      (st_b),
    .depth_o   (depth_b)
  );

  // Verdict assembly
  assign open_br = st_b.in_bracket;
  assign open_pa = !st_b.in_bracket && (depth_b != '0);
  always_comb begin
    verdict.well_formed           = (st_b.flags == '0) && !open_br && !open_pa;
    verdict.bad_control_byte      = st_b.flags[rsc_pkg::FLAG_CTRL];
    verdict.misplaced_alternation = st_b.flags[rsc_pkg::FLAG_ALT];
    verdict.misplaced_negation    = st_b.flags[rsc_pkg::FLAG_NEG];
    verdict.misplaced_quantifier  = st_b.flags[rsc_pkg::FLAG_QUANT];
    verdict.stray_close_bracket   = st_b.flags[rsc_pkg::FLAG_BRACK];
    verdict.stray_close_paren     = st_b.flags[rsc_pkg::FLAG_PAREN];
    verdict.open_bracket_at_end   = open_br;
    verdict.open_paren_at_end     = open_pa;
    verdict.depth_overflow        = st_b.flags[rsc_pkg::FLAG_OVER];
  end

  // Scan state update; the final byte returns everything to reset
  always_ff @(posedge clk) begin
    if (!rst_n || produce) begin
      held_byte_r   <= '0;
      held_valid_r  <= 1'b0;
      held_first_r  <= 1'b1;
      before_held_r <= '0;
      st_r          <= '0;
      depth_r       <= '0;
    end else if (accept) begin
      held_byte_r   <= in_symbol;
      held_valid_r  <= 1'b1;
      held_first_r  <= first_b;
      before_held_r <= prev_b;
      st_r          <= st_a;
      depth_r       <= depth_a;
    end
  end

  // Output register and skid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (out_valid_r && !out_fire) begin
      if (produce) begin
        skid_valid_r <= 1'b1;
        skid_r       <= verdict;
      end
    end else if (skid_valid_r) begin
      out_valid_r  <= 1'b1;
      out_r        <= skid_r;
      skid_valid_r <= 1'b0;
    end else begin
      out_valid_r <= produce;
      if (produce) out_r <= verdict;
    end
  end

  assign out_valid                 = out_valid_r;
  assign out_well_formed           = out_r.well_formed;
  assign out_bad_control_byte      = out_r.bad_control_byte;
  assign out_misplaced_alternation = out_r.misplaced_alternation;
  assign out_misplaced_negation    = out_r.misplaced_negation;
  assign out_misplaced_quantifier  = out_r.misplaced_quantifier;
  assign out_stray_close_bracket   = out_r.stray_close_bracket;
  assign out_stray_close_paren     = out_r.stray_close_paren;
  assign out_open_bracket_at_end   = out_r.open_bracket_at_end;
  assign out_open_paren_at_end     = out_r.open_paren_at_end;
  assign out_depth_overflow        = out_r.depth_overflow;

endmodule

[sv/rsc_checker.sv]
// Port-level checks for the syntax checker
module rsc_checker (
  input logic clk,
  input logic rst_n,
  input logic in_stall,
  input logic out_valid,
  input logic out_stall,
  input logic out_well_formed,
  input logic out_bad_control_byte,
  input logic out_misplaced_alternation,
  input logic out_misplaced_negation,
  input logic out_misplaced_quantifier,
  input logic out_stray_close_bracket,
  input logic out_stray_close_paren,
  input logic out_open_bracket_at_end,
  input logic out_open_paren_at_end,
  input logic out_depth_overflow
);

  logic any_error;
  assign any_error = out_bad_control_byte || out_misplaced_alternation ||
                     out_misplaced_negation || out_misplaced_quantifier ||
                     out_stray_close_bracket || out_stray_close_paren ||
                     out_open_bracket_at_end || out_open_paren_at_end ||
                     out_depth_overflow;

  // Verdict agrees with its flags
  a_verdict: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_well_formed == !any_error))
    else $error("well_formed disagrees with error flags");

  // An open bracket at the end masks the open paren check
  a_open_excl: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_open_bracket_at_end && out_open_paren_at_end))
    else $error("open bracket and open paren reported together");

  // Input backs up only behind a pending verdict
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid)
    else $error("input stalled with no verdict pending");

  // A stalled verdict stays offered
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) && $past(out_valid && out_stall) |-> out_valid)
    else $error("verdict dropped while stalled");

endmodule

bind regex_syntax_checker rsc_checker u_rsc_checker (
  .clk                       (clk),
  .rst_n                     (rst_n),
  .in_stall                  (in_stall),
  .out_valid                 (out_valid),
  .out_stall                 (out_stall),
  .out_well_formed           (out_well_formed),
  .out_bad_control_byte      (out_bad_control_byte),
  .out_misplaced_alternation (out_misplaced_alternation),
  .out_misplaced_negation    (out_misplaced_negation),
  .out_misplaced_quantifier  (out_misplaced_quantifier),
  .out_stray_close_bracket   (out_stray_close_bracket),
  .out_stray_close_paren     (out_stray_close_paren),
  .out_open_bracket_at_end   (out_open_bracket_at_end),
  .out_open_paren_at_end     (out_open_paren_at_end),
  .out_depth_overflow        (out_depth_overflow)
);
